@@ rtl/usmg_pkg.sv @@
// Package for the UV sphere mesh generator: sizes, stage payload types and
// elaboration-time tables (sine quarter wave, quotient and remainder steps).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package usmg_pkg;

  localparam int unsigned MAX_DIV    = 256;
  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned TABLE_BITS = 10;
  localparam int unsigned QUARTER    = 2 ** (TABLE_BITS - 2);
  localparam int unsigned DIV_W      = 9;
  localparam int unsigned PROD_W     = 2 * DIV_W;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  localparam logic signed [15:0] POS_ONE = 16'sd32767;
  localparam logic signed [15:0] NEG_ONE = -16'sd32767;

  typedef logic [ANGLE_BITS-1:0] phase_t;
  typedef logic [DIV_W-1:0]      div_t;

  typedef enum logic [1:0] {VK_RING, VK_TOP, VK_BOT} vkind_e;
  typedef enum logic [1:0] {TR_TOP, TR_MID, TR_BOT} tri_region_e;

  typedef phase_t           quot_tab_t [0:MAX_DIV];
  typedef div_t             rem_tab_t  [0:MAX_DIV];
  typedef logic [14:0]      sin_tab_t  [0:QUARTER];

  typedef struct packed {
    logic        is_tri;
    logic        fin;
    vkind_e      vkind;
    phase_t      pol_ph;
    phase_t      az_ph;
    tri_region_e treg;
    div_t        col;
    logic        last;
    logic        half;
    div_t        ring;
    div_t        lat_n;
    div_t        lon_n;
  } s1_t;

  typedef struct packed {
    logic               is_tri;
    logic               fin;
    vkind_e             vkind;
    logic signed [15:0] sp;
    logic signed [15:0] cp;
    logic signed [15:0] sa;
    logic signed [15:0] ca;
    tri_region_e        treg;
    div_t               col;
    logic               last;
    logic               half;
    logic [PROD_W-1:0]  prod;
    div_t               lat_n;
  } s2_t;

  typedef struct packed {
    phase_t ph;
    div_t   rem;
  } phase_acc_t;

  // Shift-and-subtract quotient and remainder, used only while building tables.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned umod(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) r = r - den;
    end
    return r;
  endfunction

  function automatic quot_tab_t build_quot(input int unsigned full);
    quot_tab_t t;
    for (int unsigned d = 0; d <= MAX_DIV; d++) begin
      t[d] = (d < 3) ? '0 : phase_t'(udiv(longint'(full), longint'(d)));
    end
    return t;
  endfunction

  function automatic rem_tab_t build_rem(input int unsigned full);
    rem_tab_t t;
    for (int unsigned d = 0; d <= MAX_DIV; d++) begin
      t[d] = (d < 3) ? '0 : div_t'(umod(longint'(full), longint'(d)));
    end
    return t;
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    longint unsigned x, x2, term, v;
    longint sum;
    for (int unsigned k = 0; k <= QUARTER; k++) begin
      x = (PI_Q30 * longint'(k)) >> (TABLE_BITS - 1);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int unsigned n = 1; n <= 12; n++) begin
        term = udiv((term * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
        if (n[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (longint'(sum) * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      t[k] = v[14:0];
    end
    return t;
  endfunction

  localparam quot_tab_t AZ_QUOT  = build_quot(2 ** ANGLE_BITS);
  localparam rem_tab_t  AZ_REM   = build_rem(2 ** ANGLE_BITS);
  localparam quot_tab_t POL_QUOT = build_quot(2 ** (ANGLE_BITS - 1));
  localparam rem_tab_t  POL_REM  = build_rem(2 ** (ANGLE_BITS - 1));
  localparam sin_tab_t  SIN_TAB  = build_sin_tab();

  function automatic div_t eff_div(input div_t v);
    if (v < div_t'(3)) return div_t'(3);
    if (v > div_t'(MAX_DIV)) return div_t'(MAX_DIV);
    return v;
  endfunction

  function automatic phase_acc_t phase_step(input phase_acc_t a, input phase_t q,
                                            input div_t r, input div_t dv);
    phase_acc_t o;
    logic [DIV_W:0] m;
    o.ph = a.ph + q;
    m = {1'b0, a.rem} + {1'b0, r};
    if (m >= {1'b0, dv}) begin
      m = m - {1'b0, dv};
      o.ph = o.ph + phase_t'(1);
    end
    o.rem = m[DIV_W-1:0];
    return o;
  endfunction

  function automatic logic [TABLE_BITS-1:0] phase_index(input phase_t ph);
    logic [ANGLE_BITS:0] s;
    s = {1'b0, ph} + (ANGLE_BITS+1)'(1 << (ANGLE_BITS - TABLE_BITS - 1));
    return s[ANGLE_BITS-1:ANGLE_BITS-TABLE_BITS];
  endfunction

  function automatic logic signed [15:0] sin_at(input logic [TABLE_BITS-1:0] i);
    logic [1:0] quad;
    logic [TABLE_BITS-2:0] j;
    logic [15:0] val;
    quad = i[TABLE_BITS-1:TABLE_BITS-2];
    j = {1'b0, i[TABLE_BITS-3:0]};
    if (quad[0]) j = (TABLE_BITS-1)'(QUARTER) - j;
    val = {1'b0, SIN_TAB[j]};
    return quad[1] ? -$signed(val) : $signed(val);
  endfunction

endpackage
`default_nettype wire

@@ rtl/usmg_if.sv @@
// Request and response channel interfaces of the UV sphere mesh generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface usmg_req_if;
  logic valid;
  logic ready;
  logic func;
  logic restart;
  modport source (output valid, func, restart, input ready);
  modport sink (input valid, func, restart, output ready);
endinterface

interface usmg_rsp_if;
  logic               valid;
  logic               ready;
  logic               is_triangle;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [15:0]        corner_a;
  logic [15:0]        corner_b;
  logic [15:0]        corner_c;
  logic               final_element;
  modport source (output valid, is_triangle, pos_x, pos_y, pos_z, corner_a, corner_b,
                  corner_c, final_element, input ready);
  modport sink (input valid, is_triangle, pos_x, pos_y, pos_z, corner_a, corner_b,
                corner_c, final_element, output ready);
endinterface
`default_nettype wire

@@ rtl/usmg_seq.sv @@
// First cell: vertex and triangle stream counters with phase accumulators.
// Depends on usmg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module usmg_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          fire_i,
  input  wire logic          func_i,
  input  wire logic          restart_i,
  input  usmg_pkg::div_t     lat_n_i,
  input  usmg_pkg::div_t     lon_n_i,
  output logic               valid_o,
  output usmg_pkg::s1_t      data_o
);
  import usmg_pkg::*;

  div_t        vring_q, vring_d, vcol_q, vcol_d;
  phase_acc_t  az_q, az_d, pol_q, pol_d;
  tri_region_e treg_q, treg_d;
  div_t        tring_q, tring_d, tcol_q, tcol_d;
  logic        thalf_q, thalf_d;
  logic        valid_q;
  s1_t         data_q, s1;

  div_t        vr, vc, tr, tc;
  phase_acc_t  az, pol;
  tri_region_e rg;
  logic        th, last;

  always_comb begin
    vring_d = vring_q; vcol_d = vcol_q; az_d = az_q; pol_d = pol_q;
    treg_d = treg_q; tring_d = tring_q; tcol_d = tcol_q; thalf_d = thalf_q;
    vr = restart_i ? '0 : vring_q;
    vc = restart_i ? '0 : vcol_q;
    az = restart_i ? '0 : az_q;
    pol = restart_i ? '0 : pol_q;
    rg = restart_i ? TR_TOP : treg_q;
    tr = restart_i ? '0 : tring_q;
    tc = restart_i ? '0 : tcol_q;
    th = restart_i ? 1'b0 : thalf_q;
    if (rg != TR_TOP && rg != TR_MID && rg != TR_BOT) begin
      rg = TR_TOP; tr = '0; tc = '0; th = 1'b0;
    end
    last = ({1'b0, tc} + 10'd1) >= {1'b0, lat_n_i};
    s1 = '0;
    s1.is_tri = func_i;
    s1.lat_n = lat_n_i;
    s1.lon_n = lon_n_i;
    if (!func_i) begin
      if (vr == '0) begin
        s1.vkind = VK_TOP;
        vring_d = div_t'(1); vcol_d = '0; az_d = '0;
        pol_d = phase_step(pol, POL_QUOT[lon_n_i], POL_REM[lon_n_i], lon_n_i);
      end else if (vr >= lon_n_i) begin
        s1.vkind = VK_BOT;
        s1.fin = 1'b1;
        vring_d = '0; vcol_d = '0; az_d = '0; pol_d = '0;
      end else begin
        s1.vkind = VK_RING;
        s1.pol_ph = pol.ph;
        s1.az_ph = az.ph;
        if (({1'b0, vc} + 10'd1) >= {1'b0, lat_n_i}) begin
          vcol_d = '0; az_d = '0;
          pol_d = phase_step(pol, POL_QUOT[lon_n_i], POL_REM[lon_n_i], lon_n_i);
          vring_d = vr + div_t'(1);
        end else begin
          vcol_d = vc + div_t'(1);
          az_d = phase_step(az, AZ_QUOT[lat_n_i], AZ_REM[lat_n_i], lat_n_i);
          vring_d = vr; pol_d = pol;
        end
      end
    end else begin
      s1.treg = rg;
      s1.col = tc;
      s1.last = last;
      s1.half = th;
      s1.ring = tr;
      treg_d = rg; tring_d = tr; tcol_d = tc; thalf_d = th;
      unique case (rg)
        TR_MID: begin
          if (!th) begin
            thalf_d = 1'b1;
          end else begin
            thalf_d = 1'b0;
            if (last) begin
              tcol_d = '0;
              if (({1'b0, tr} + 10'd1) >= ({1'b0, lon_n_i} - 10'd2)) begin
                treg_d = TR_BOT; tring_d = '0;
              end else begin
                tring_d = tr + div_t'(1);
              end
            end else begin
              tcol_d = tc + div_t'(1);
            end
          end
        end
        TR_BOT: begin
          if (last) begin
            s1.fin = 1'b1;
            treg_d = TR_TOP; tring_d = '0; tcol_d = '0; thalf_d = 1'b0;
          end else begin
            tcol_d = tc + div_t'(1);
          end
        end
        default: begin
          if (last) begin
            tcol_d = '0; treg_d = TR_MID; tring_d = '0; thalf_d = 1'b0;
          end else begin
            tcol_d = tc + div_t'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vring_q <= '0; vcol_q <= '0; az_q <= '0; pol_q <= '0;
      treg_q <= TR_TOP; tring_q <= '0; tcol_q <= '0; thalf_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (fire_i && !func_i) begin
        vring_q <= vring_d; vcol_q <= vcol_d; az_q <= az_d; pol_q <= pol_d;
      end
      if (fire_i && func_i) begin
        treg_q <= treg_d; tring_q <= tring_d; tcol_q <= tcol_d; thalf_q <= thalf_d;
      end
      if (adv_i) valid_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) data_q <= s1;
  end

  assign valid_o = valid_q;
  assign data_o = data_q;
endmodule
`default_nettype wire

@@ rtl/usmg_lookup.sv @@
// Second cell: sine table lookups for vertices, row base product for triangles.
// Depends on usmg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module usmg_lookup (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     adv_i,
  input  wire logic     valid_i,
  input  usmg_pkg::s1_t data_i,
  output logic          valid_o,
  output usmg_pkg::s2_t data_o
);
  import usmg_pkg::*;

  logic valid_q;
  s2_t  data_q, s2;
  logic [TABLE_BITS-1:0] pi, ai;
  localparam logic [TABLE_BITS-1:0] QOFF = TABLE_BITS'(QUARTER);
  div_t mul_a;

  always_comb begin
    pi = phase_index(data_i.pol_ph);
    ai = phase_index(data_i.az_ph);
    mul_a = (data_i.treg == TR_BOT) ? data_i.lon_n - div_t'(1) : data_i.ring;
    s2.is_tri = data_i.is_tri;
    s2.fin = data_i.fin;
    s2.vkind = data_i.vkind;
    s2.sp = sin_at(pi);
    s2.cp = sin_at(pi + QOFF);
    s2.sa = sin_at(ai);
    s2.ca = sin_at(ai + QOFF);
    s2.treg = data_i.treg;
    s2.col = data_i.col;
    s2.last = data_i.last;
    s2.half = data_i.half;
    s2.prod = mul_a * data_i.lat_n;
    s2.lat_n = data_i.lat_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) data_q <= s2;
  end

  assign valid_o = valid_q;
  assign data_o = data_q;
endmodule
`default_nettype wire

@@ rtl/usmg_mix.sv @@
// Last cell: Q1.15 products for vertex positions, corner indices for triangles,
// and the output register. Depends on usmg_pkg and usmg_if.
`timescale 1ns / 1ps
`default_nettype none
module usmg_mix (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      adv_i,
  input  wire logic      valid_i,
  input  usmg_pkg::s2_t  data_i,
  usmg_rsp_if.source     rsp
);
  import usmg_pkg::*;

  logic               valid_q;
  logic               tri_q, fin_q;
  logic signed [15:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic [15:0]        a_q, b_q, c_q, a_d, b_d, c_d;
  logic signed [31:0] px, pz;
  logic [15:0]        lw, cw, start, lat, nxt, bot, base;

  always_comb begin
    px = 32'(data_i.sp) * 32'(data_i.ca) + 32'sd16384;
    pz = 32'(data_i.sp) * 32'(data_i.sa) + 32'sd16384;
    lw = 16'(data_i.lat_n);
    cw = 16'(data_i.col);
    start = 16'(data_i.prod) + 16'd1;
    lat = start + cw;
    nxt = data_i.last ? start : lat + 16'd1;
    bot = start;
    base = bot - lw;
    x_d = '0; y_d = '0; z_d = '0; a_d = '0; b_d = '0; c_d = '0;
    if (!data_i.is_tri) begin
      unique case (data_i.vkind)
        VK_TOP: y_d = POS_ONE;
        VK_BOT: y_d = NEG_ONE;
        default: begin
          x_d = px[30:15];
          y_d = data_i.cp;
          z_d = pz[30:15];
        end
      endcase
    end else begin
      unique case (data_i.treg)
        TR_MID: begin
          if (!data_i.half) begin
            a_d = lat; b_d = lat + lw; c_d = nxt;
          end else begin
            a_d = lat + lw; b_d = nxt + lw; c_d = nxt;
          end
        end
        TR_BOT: begin
          a_d = bot;
          b_d = data_i.last ? base : base + cw + 16'd1;
          c_d = base + cw;
        end
        default: begin
          b_d = cw + 16'd1;
          c_d = data_i.last ? 16'd1 : cw + 16'd2;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tri_q <= data_i.is_tri; fin_q <= data_i.fin;
      x_q <= x_d; y_q <= y_d; z_q <= z_d;
      a_q <= a_d; b_q <= b_d; c_q <= c_d;
    end
  end

  assign rsp.valid = valid_q;
  assign rsp.is_triangle = tri_q;
  assign rsp.pos_x = x_q;
  assign rsp.pos_y = y_q;
  assign rsp.pos_z = z_q;
  assign rsp.corner_a = a_q;
  assign rsp.corner_b = b_q;
  assign rsp.corner_c = c_q;
  assign rsp.final_element = fin_q;
endmodule
`default_nettype wire

@@ rtl/uv_sphere_mesh_generator_top.sv @@
// Top level of the UV sphere mesh generator: configuration registers and the
// three-cell chain. Depends on usmg_pkg, usmg_if, usmg_seq, usmg_lookup, usmg_mix.
//
// Channel   Direction  Carries
// req_i     in         func, restart
// rsp_o     out        is_triangle, pos_x/y/z, corner_a/b/c, final_element
// cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// One beat is accepted per cycle while the output is not stalled; its result is
// registered in the counter, lookup and output cells before it is presented.
// The chain runs counters, then table lookup and row product, then multiply and corner indices.
// All cells stall together while a finished beat waits at the output.
// Reset restores both division counts to 16 and rewinds both streams.
`timescale 1ns / 1ps
`default_nettype none
module uv_sphere_mesh_generator_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  usmg_req_if.sink        req_i,
  usmg_rsp_if.source      rsp_o,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  usmg_pkg::div_t  cfg_data_i
);
  import usmg_pkg::*;

  localparam logic IDX_LAT = 1'b0;
  localparam logic IDX_LON = 1'b1;

  div_t lat_q, lon_q;
  logic adv, fire, v1, v2;
  s1_t  d1;
  s2_t  d2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= div_t'(16);
      lon_q <= div_t'(16);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        IDX_LAT: lat_q <= cfg_data_i;
        default: lon_q <= cfg_data_i;
      endcase
    end
  end

  assign adv = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = adv;
  assign fire = req_i.valid && adv;

  usmg_seq u_seq (
    .clk_i, .rst_ni, .adv_i(adv), .fire_i(fire), .func_i(req_i.func),
    .restart_i(req_i.restart), .lat_n_i(eff_div(lat_q)), .lon_n_i(eff_div(lon_q)),
    .valid_o(v1), .data_o(d1)
  );

  usmg_lookup u_lookup (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(v1), .data_i(d1), .valid_o(v2), .data_o(d2)
  );

  usmg_mix u_mix (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(v2), .data_i(d2), .rsp(rsp_o)
  );
endmodule
`default_nettype wire
